// ----- sv/sgr_pkg.sv -----
// Shared types, constants, font table and control program of the glyph renderer.
`default_nettype none
package sgr_pkg;

  localparam int PANEL_EDGE_DEF = 240;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_RED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_GREEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_BLUE  = 2'd3;

  localparam logic       MODE_PRINT = 1'b0;
  localparam logic [7:0] FONT_FIRST = 8'd32;
  localparam logic [7:0] FONT_LAST  = 8'd127;
  localparam int         FONT_COLS  = 6;
  localparam int         FONT_ROWS  = 8;
  localparam int         FONT_CODES = 96;

  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_FETCH = 2'd1;
  localparam step_t STEP_EMIT  = 2'd2;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_PRINT,
    COND_ROW_MORE,
    COND_COL_DONE
  } cond_t;

  // One control word of the program.
  typedef struct packed {
    logic  take_in;
    logic  fetch;
    logic  emit;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } cword_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic print_req;
    logic row_more;
    logic col_done;
    logic out_busy;
  } stat_t;

  function automatic cword_t prog_rom(input step_t step);
    cword_t cw;
    cw = '{take_in: 1'b0, fetch: 1'b0, emit: 1'b0, cond: COND_NONE,
           tgt: STEP_IDLE, nxt: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_PRINT;
        cw.tgt     = STEP_FETCH;
        cw.nxt     = STEP_IDLE;
      end
      STEP_FETCH: begin
        cw.fetch = 1'b1;
        cw.cond  = COND_COL_DONE;
        cw.tgt   = STEP_IDLE;
        cw.nxt   = STEP_EMIT;
      end
      STEP_EMIT: begin
        cw.emit = 1'b1;
        cw.cond = COND_ROW_MORE;
        cw.tgt  = STEP_EMIT;
        cw.nxt  = STEP_FETCH;
      end
      default: begin
        cw.nxt = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

  // Font: column 0 in the top byte, bit 7 of a column is the top row.
  localparam logic [47:0] GLYPH_ROM [FONT_CODES] = '{
    48'h000000000000, 48'h00FA00000000, 48'h006000600000, 48'h28FE28FE2800,
    48'h2454D6544800, 48'hC20C10608600, 48'h0C52BA4C1200, 48'h000060000000,
    48'h003844820000, 48'h008244380000, 48'h005020500000, 48'h10107C101000,
    48'h000102000000, 48'h001010100000, 48'h000002000000, 48'h020C10608000,
    48'h7C8A92A27C00, 48'h0242FE020200, 48'h468A92926600, 48'h448292926C00,
    48'h18284888FE00, 48'hE4A2A2A29C00, 48'h3C5292920C00, 48'hC0808E90E000,
    48'h6C9292926C00, 48'h609292947800, 48'h000024000000, 48'h000224000000,
    48'h102844820000, 48'h242424240000, 48'h824428100000, 48'h40808A906000,
    48'h3C425A4A3A00, 48'h7E9090907E00, 48'hFE9292926C00, 48'h7C8282824400,
    48'hFE8282827C00, 48'hFE9292928200, 48'hFE9090908000, 48'h7C8282A2BC00,
    48'hFE101010FE00, 48'h0082FE820000, 48'h04020202FC00, 48'hFE2020508E00,
    48'hFE0202020000, 48'hFE402040FE00, 48'hFE402010FE00, 48'h7C8282827C00,
    48'hFE9090906000, 48'h7C8282847A00, 48'hFE9090906E00, 48'h649292924C00,
    48'h8080FE808000, 48'hFC020202FC00, 48'hF00C020CF000, 48'hFE040804FE00,
    48'hC6281028C600, 48'h80403E408000, 48'h868A92A2C200, 48'h00FE82820000,
    48'h8060100C0200, 48'h008282FE0000, 48'h204080402000, 48'h010101010100,
    48'h402000000000, 48'h042A2A2A1E00, 48'h7E1222221C00, 48'h1C2222221400,
    48'h1C2222127E00, 48'h1C2A2A2A1A00, 48'h207EA0A00000, 48'h192525253E00,
    48'hFE1020201E00, 48'h0020BC020000, 48'h04020202BC00, 48'h00FE08142200,
    48'h0080FC020200, 48'h3E2018201E00, 48'h3E2020201E00, 48'h1C2222221C00,
    48'h3F1424241800, 48'h182424143F00, 48'h3E1020201000, 48'h122A2A2A2400,
    48'h0020FC220000, 48'h3C0202023E00, 48'h380402043800, 48'h3C020E023E00,
    48'h221408142200, 48'h390505053E00, 48'h22262A322200, 48'h00106C820000,
    48'h0000FE000000, 48'h00826C100000, 48'h182010083000, 48'h000000000000
  };

  // Column bits of a code; codes outside the font and column indexes past
  // the glyph read blank.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [47:0] ent;
    logic [7:0]  bits;
    ent  = 48'd0;
    bits = 8'd0;
    if (code >= FONT_FIRST && code <= FONT_LAST) begin
      ent = GLYPH_ROM[7'(code - FONT_FIRST)];
    end
    case (col)
      3'd0:    bits = ent[47:40];
      3'd1:    bits = ent[39:32];
      3'd2:    bits = ent[31:24];
      3'd3:    bits = ent[23:16];
      3'd4:    bits = ent[15:8];
      3'd5:    bits = ent[7:0];
      default: bits = 8'd0;
    endcase
    return bits;
  endfunction

endpackage
`default_nettype wire

// ----- sv/sgr_seq.sv -----
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none
module sgr_seq (
  input  wire            clk,
  input  wire            rst_n,
  input  sgr_pkg::stat_t stat,
  output sgr_pkg::cword_t cw,
  output logic           go
);

  sgr_pkg::step_t step_r, step_nxt;
  logic           cond_hit;

  assign cw = sgr_pkg::prog_rom(step_r);
  // Hold the step while an emit waits on a full output register.
  assign go = !(cw.emit && stat.out_busy);

  always_comb begin
    case (cw.cond)
      sgr_pkg::COND_NONE:     cond_hit = 1'b0;
      sgr_pkg::COND_PRINT:    cond_hit = stat.print_req;
      sgr_pkg::COND_ROW_MORE: cond_hit = stat.row_more;
      sgr_pkg::COND_COL_DONE: cond_hit = stat.col_done;
      default:                cond_hit = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = cw.tgt;
    end else begin
      step_nxt = cw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sgr_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sgr_dp.sv -----
// Datapath: config registers, cursor, glyph column shifter and output register.
`default_nettype none
module sgr_dp #(
  parameter int PANEL_EDGE = sgr_pkg::PANEL_EDGE_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  sgr_pkg::cword_t                   cw,
  input  wire                               go,
  output sgr_pkg::stat_t                    stat,
  input  wire                               cfg_we,
  input  wire [sgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                               in_tvalid,
  input  wire [23:0]                        in_tdata,
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [39:0]                       out_tdata,
  output logic                              out_tlast
);

  localparam logic [8:0] EDGE9 = 9'(PANEL_EDGE);

  logic [3:0] scale_r;
  logic [5:0] red_r, green_r, blue_r;
  logic [7:0] cur_col_r, cur_row_r;
  logic [7:0] code_r;
  logic [2:0] col_r, row_r;
  logic [7:0] glyph_r;
  logic [7:0] yoff_r;
  logic       ovalid_r;
  logic [7:0] ox_r, oy_r;
  logic [5:0] ored_r, ogreen_r, oblue_r;
  logic       olast_r;

  logic       accept, emit_go, on, row_last, col_last;
  logic [8:0] csum, rsum;
  logic [7:0] col_nxt, row_nxt;

  assign accept   = cw.take_in && in_tvalid;
  assign emit_go  = cw.emit && go;
  assign on       = glyph_r[7];
  assign row_last = (row_r == 3'(sgr_pkg::FONT_ROWS - 1));
  assign col_last = (col_r == 3'(sgr_pkg::FONT_COLS - 1));

  assign stat.print_req = in_tvalid && (in_tuser == sgr_pkg::MODE_PRINT);
  assign stat.row_more  = !row_last;
  assign stat.col_done  = (col_r == 3'(sgr_pkg::FONT_COLS));
  assign stat.out_busy  = ovalid_r && !out_tready;

  // Column step, compares at full width before truncation.
  always_comb begin
    csum    = {1'b0, cur_col_r} + {5'd0, scale_r};
    rsum    = {1'b0, cur_row_r};
    col_nxt = csum[7:0];
    if (csum >= EDGE9) begin
      col_nxt = 8'd0;
      rsum    = {1'b0, cur_row_r} + {2'd0, scale_r, 3'd0};
    end
    row_nxt = rsum[7:0];
    if (rsum >= EDGE9) begin
      col_nxt = 8'd0;
      row_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 4'd1;
      red_r     <= 6'd63;
      green_r   <= 6'd63;
      blue_r    <= 6'd63;
      cur_col_r <= 8'd0;
      cur_row_r <= 8'd0;
      ovalid_r  <= 1'b0;
      col_r     <= 3'd0;
      row_r     <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgr_pkg::REG_SCALE:      scale_r <= cfg_data[3:0];
          sgr_pkg::REG_FORE_RED:   red_r   <= cfg_data;
          sgr_pkg::REG_FORE_GREEN: green_r <= cfg_data;
          sgr_pkg::REG_FORE_BLUE:  blue_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (in_tuser == sgr_pkg::MODE_PRINT) begin
          col_r <= 3'd0;
        end else begin
          cur_col_r <= in_tdata[15:8];
          cur_row_r <= in_tdata[23:16];
        end
      end
      if (cw.fetch) begin
        row_r <= 3'd0;
      end
      if (emit_go) begin
        row_r <= row_r + 3'd1;
        if (row_last) begin
          col_r     <= col_r + 3'd1;
          cur_col_r <= col_nxt;
          cur_row_r <= row_nxt;
        end
      end
      if (emit_go) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_tdata[7:0];
    end
    if (cw.fetch) begin
      glyph_r <= sgr_pkg::glyph_col(code_r, col_r);
      yoff_r  <= 8'd0;
    end
    if (emit_go) begin
      glyph_r  <= {glyph_r[6:0], 1'b0};
      yoff_r   <= yoff_r + {4'd0, scale_r};
      ox_r     <= cur_col_r;
      oy_r     <= cur_row_r + yoff_r;
      ored_r   <= on ? red_r : 6'd0;
      ogreen_r <= on ? green_r : 6'd0;
      oblue_r  <= on ? blue_r : 6'd0;
      olast_r  <= row_last && col_last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, oblue_r, ogreen_r, ored_r, oy_r, ox_r};
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

// ----- sv/scaled_glyph_renderer.sv -----
// Top level of the scaled glyph renderer: sequencer, datapath and checks.
`default_nettype none
// Character generator with a built-in 6x8 font for codes 32 to 127. An item
// with in_tuser low prints in_tdata's code at the cursor: it yields 48 block
// items, column by column and top row first, each a square of scale pixels
// in the foreground color for a set glyph bit and black otherwise; the last
// one carries out_tlast. After each column the cursor moves right by scale,
// wraps to the next text line at the panel edge and back to 0,0 past the
// bottom. An item with in_tuser high loads the cursor and yields nothing.
// Codes outside the font print blank. A three-step control program runs the
// block: an idle step takes items, a fetch step loads a glyph column, an
// emit step repeats once per row. Between a print item's accept and the
// next possible accept lie the accept, for each of the six glyph columns a
// fetch and one emit per row, and a closing fetch-step check, with stalls
// when out_tready is low; the emit step holds one block per cycle at most
// through the single output register. A load item keeps the idle step. A
// new item may be taken while the last block still waits in the output register.
module scaled_glyph_renderer #(
  parameter int PANEL_EDGE = sgr_pkg::PANEL_EDGE_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // config: index 0 scale, 1 fore_red, 2 fore_green, 3 fore_blue
  input  wire                           cfg_we,
  input  wire [sgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // in_tdata: [7:0] char_code, [15:8] new_col, [23:16] new_row
  input  wire [23:0]                    in_tdata,
  // in_tuser: [0] mode
  input  wire                           in_tuser,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  // out_tdata: [7:0] block_x, [15:8] block_y, [21:16] out_red,
  // [27:22] out_green, [33:28] out_blue, [39:34] zero
  output logic [39:0]                   out_tdata,
  // out_tlast: final_block
  output logic                          out_tlast
);

  sgr_pkg::cword_t cw;
  sgr_pkg::stat_t  stat;
  logic            go;

  sgr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw),
    .go    (go)
  );

  sgr_dp #(
    .PANEL_EDGE (PANEL_EDGE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .go         (go),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Take items only in the idle step.
  assign in_tready = cw.take_in;

  // A print item leaves the idle step for its glyph.
  a_print_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("print item did not start the program");

  // A load item keeps the block idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> in_tready)
    else $error("load item left the idle step");

  // A block only appears after an emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cw.emit))
    else $error("block appeared without an emit step");

endmodule
`default_nettype wire

// ----- bench/tb_glyph_pkg.sv -----
// Font copy, block record and expected-block board for the glyph renderer bench.
`timescale 1ns / 1ps
package tb_glyph_pkg;

  localparam logic MODE_LOAD = ~sgr_pkg::MODE_PRINT;
  localparam int   PANEL_EDGE = sgr_pkg::PANEL_EDGE_DEF;

  // One painted square as it leaves the block.
  typedef struct packed {
    logic [7:0] bx;
    logic [7:0] by;
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
    logic       tail;
  } block_t;

  // Column 0 in the top byte, bit 7 of each column is the top row.
  localparam logic [47:0] FONT_BITS [96] = '{
    48'h000000000000, 48'h00FA00000000, 48'h006000600000, 48'h28FE28FE2800,
    48'h2454D6544800, 48'hC20C10608600, 48'h0C52BA4C1200, 48'h000060000000,
    48'h003844820000, 48'h008244380000, 48'h005020500000, 48'h10107C101000,
    48'h000102000000, 48'h001010100000, 48'h000002000000, 48'h020C10608000,
    48'h7C8A92A27C00, 48'h0242FE020200, 48'h468A92926600, 48'h448292926C00,
    48'h18284888FE00, 48'hE4A2A2A29C00, 48'h3C5292920C00, 48'hC0808E90E000,
    48'h6C9292926C00, 48'h609292947800, 48'h000024000000, 48'h000224000000,
    48'h102844820000, 48'h242424240000, 48'h824428100000, 48'h40808A906000,
    48'h3C425A4A3A00, 48'h7E9090907E00, 48'hFE9292926C00, 48'h7C8282824400,
    48'hFE8282827C00, 48'hFE9292928200, 48'hFE9090908000, 48'h7C8282A2BC00,
    48'hFE101010FE00, 48'h0082FE820000, 48'h04020202FC00, 48'hFE2020508E00,
    48'hFE0202020000, 48'hFE402040FE00, 48'hFE402010FE00, 48'h7C8282827C00,
    48'hFE9090906000, 48'h7C8282847A00, 48'hFE9090906E00, 48'h649292924C00,
    48'h8080FE808000, 48'hFC020202FC00, 48'hF00C020CF000, 48'hFE040804FE00,
    48'hC6281028C600, 48'h80403E408000, 48'h868A92A2C200, 48'h00FE82820000,
    48'h8060100C0200, 48'h008282FE0000, 48'h204080402000, 48'h010101010100,
    48'h402000000000, 48'h042A2A2A1E00, 48'h7E1222221C00, 48'h1C2222221400,
    48'h1C2222127E00, 48'h1C2A2A2A1A00, 48'h207EA0A00000, 48'h192525253E00,
    48'hFE1020201E00, 48'h0020BC020000, 48'h04020202BC00, 48'h00FE08142200,
    48'h0080FC020200, 48'h3E2018201E00, 48'h3E2020201E00, 48'h1C2222221C00,
    48'h3F1424241800, 48'h182424143F00, 48'h3E1020201000, 48'h122A2A2A2400,
    48'h0020FC220000, 48'h3C0202023E00, 48'h380402043800, 48'h3C020E023E00,
    48'h221408142200, 48'h390505053E00, 48'h22262A322200, 48'h00106C820000,
    48'h0000FE000000, 48'h00826C100000, 48'h182010083000, 48'h000000000000
  };

  class glyph_block_board;
    logic [3:0] scale_q;
    logic [5:0] red_q;
    logic [5:0] green_q;
    logic [5:0] blue_q;
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    block_t     blocks_due[$];
    int         errors;

    function new();
      scale_q = 4'd1;
      red_q   = 6'd63;
      green_q = 6'd63;
      blue_q  = 6'd63;
      cur_col = 8'd0;
      cur_row = 8'd0;
      errors  = 0;
    endfunction

    function void write_reg(input logic [1:0] index, input logic [5:0] value);
      case (index)
        sgr_pkg::REG_SCALE:      scale_q = value[3:0];
        sgr_pkg::REG_FORE_RED:   red_q   = value;
        sgr_pkg::REG_FORE_GREEN: green_q = value;
        sgr_pkg::REG_FORE_BLUE:  blue_q  = value;
        default: ;
      endcase
    endfunction

    // Work out the 48 blocks of a print item and advance the cursor; a load item only sets the cursor.
    function void predict_blocks(input logic mode, input logic [7:0] code,
                                 input logic [7:0] col, input logic [7:0] row);
      logic [7:0] bits;
      logic       lit;
      block_t     blk;
      int         c;
      int         r;
      int         csum;
      int         rsum;
      bit         in_font;
      if (mode != sgr_pkg::MODE_PRINT) begin
        cur_col = col;
        cur_row = row;
        return;
      end
      in_font = (code >= 8'd32) && (code <= 8'd127);
      for (c = 0; c < 6; c++) begin
        bits = in_font ? FONT_BITS[int'(code) - 32][47 - 8 * c -: 8] : 8'h00;
        for (r = 0; r < 8; r++) begin
          lit       = bits[7 - r];
          blk.bx    = cur_col;
          blk.by    = 8'(int'(cur_row) + r * int'(scale_q));
          blk.red   = lit ? red_q : 6'd0;
          blk.green = lit ? green_q : 6'd0;
          blk.blue  = lit ? blue_q : 6'd0;
          blk.tail  = (c == 5) && (r == 7);
          blocks_due.push_back(blk);
        end
        csum = int'(cur_col) + int'(scale_q);
        rsum = int'(cur_row);
        if (csum >= PANEL_EDGE) begin
          cur_col = 8'd0;
          rsum    = int'(cur_row) + 8 * int'(scale_q);
        end else begin
          cur_col = 8'(csum);
        end
        if (rsum >= PANEL_EDGE) begin
          cur_col = 8'd0;
          cur_row = 8'd0;
        end else begin
          cur_row = 8'(rsum);
        end
      end
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_block(input logic [39:0] data, input logic last);
      block_t got;
      block_t want;
      got = '{bx: data[7:0], by: data[15:8], red: data[21:16], green: data[27:22],
              blue: data[33:28], tail: last};
      if (blocks_due.size() == 0) begin
        flag($sformatf("unexpected block x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b",
                       got.bx, got.by, got.red, got.green, got.blue, got.tail));
        return;
      end
      want = blocks_due.pop_front();
      if (got !== want || data[39:34] !== 6'd0) begin
        flag($sformatf({"expected x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b, ",
                        "got x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b pad=%0h"},
                       want.bx, want.by, want.red, want.green, want.blue, want.tail,
                       got.bx, got.by, got.red, got.green, got.blue, got.tail,
                       data[39:34]));
      end
    endfunction

    function int pending();
      return blocks_due.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_scaled_glyph_renderer.sv -----
// Top-level bench: drives print and cursor-load items through the glyph renderer.
`timescale 1ns / 1ps
module tb_scaled_glyph_renderer;

  // Cycles without any accepted item before the run is declared hung; the limit
  // lies well above the long receiver hold-off and a print item together.
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  // Let the sequencer finish its closing step before touching registers.
  localparam int SETTLE_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] char_code, [15:8] new_col, [23:16] new_row
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] x, [15:8] y, [21:16] r, [27:22] g, [33:28] b
  logic        out_tlast;  // final block of a character

  tb_glyph_pkg::glyph_block_board board;
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int idle_cycles;

  scaled_glyph_renderer #(.PANEL_EDGE(tb_glyph_pkg::PANEL_EDGE)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every accepted block against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_block(out_tdata, out_tlast);
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: draw a wait before each block; on request hold off for a long
  // stretch so the output register fills and the input side stalls.
  initial begin : rx_side
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one item after a drawn gap and hold it until accepted. Valid stays
  // high on return so back-to-back items need no extra edge.
  task automatic send_item(input logic mode, input logic [7:0] code,
                           input logic [7:0] col, input logic [7:0] row);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= mode;
    in_tdata  <= {row, col, code};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.predict_blocks(mode, code, col, row);
    @(negedge clk);
  endtask

  // Mostly printable codes, a share of cursor loads biased toward the panel
  // edge so that wraps happen often; the rest spans the full byte range.
  task automatic send_random_item();
    logic       mode;
    logic [7:0] code;
    logic [7:0] col;
    logic [7:0] row;
    mode = ($urandom_range(0, 99) < 25) ? tb_glyph_pkg::MODE_LOAD : sgr_pkg::MODE_PRINT;
    code = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(32, 127)) : 8'($urandom);
    col  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(224, 255)) : 8'($urandom);
    row  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(224, 255)) : 8'($urandom);
    send_item(mode, code, col, row);
  endtask

  // Drop valid, wait for every expected block, then let the block go idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    board.write_reg(index, value);
    @(negedge clk);
  endtask

  // One setting of all four registers followed by a run of random items.
  task automatic run_phase(input logic [5:0] sc, input logic [5:0] r,
                           input logic [5:0] g, input logic [5:0] b,
                           input int count, input bit txs, input bit rxs,
                           input bit press, input bit pause);
    int i;
    drain();
    write_reg(sgr_pkg::REG_SCALE, sc);
    write_reg(sgr_pkg::REG_FORE_RED, r);
    write_reg(sgr_pkg::REG_FORE_GREEN, g);
    write_reg(sgr_pkg::REG_FORE_BLUE, b);
    cfg_we    <= 1'b0;
    tx_steady = txs;
    rx_steady = rxs;
    hold_req  = press;
    for (i = 0; i < count; i++) begin
      // Halfway through, hold the sender until the pipe is empty.
      if (pause && i == count / 2) begin
        in_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_random_item();
    end
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = 24'd0;
    in_tuser    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = 2'd0;
    cfg_data    = 6'd0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    board       = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings: glyph edges of the font, codes just
    // outside it, the full byte range, and ignored fields set to all ones.
    send_item(sgr_pkg::MODE_PRINT, 8'd65, 8'hFF, 8'hFF);
    send_item(sgr_pkg::MODE_PRINT, 8'd32, 8'h00, 8'h00);
    send_item(sgr_pkg::MODE_PRINT, 8'd127, 8'h00, 8'h00);
    send_item(sgr_pkg::MODE_PRINT, 8'd0, 8'h00, 8'h00);
    send_item(sgr_pkg::MODE_PRINT, 8'd31, 8'h00, 8'h00);
    send_item(sgr_pkg::MODE_PRINT, 8'd128, 8'h00, 8'h00);
    send_item(sgr_pkg::MODE_PRINT, 8'd255, 8'h00, 8'h00);
    // Loaded cursor past the edge: it stands until the first column step.
    send_item(tb_glyph_pkg::MODE_LOAD, 8'd65, 8'd255, 8'd255);
    send_item(sgr_pkg::MODE_PRINT, 8'd33, 8'h00, 8'h00);
    // Column wrap to the next text line after the last column of a glyph.
    send_item(tb_glyph_pkg::MODE_LOAD, 8'hFF, 8'd234, 8'd0);
    send_item(sgr_pkg::MODE_PRINT, 8'd87, 8'h00, 8'h00);
    // Wrap at the bottom right corner back to the origin.
    send_item(tb_glyph_pkg::MODE_LOAD, 8'h00, 8'd239, 8'd232);
    send_item(sgr_pkg::MODE_PRINT, 8'd77, 8'h00, 8'h00);
    send_item(tb_glyph_pkg::MODE_LOAD, 8'h00, 8'd0, 8'd0);
    send_item(sgr_pkg::MODE_PRINT, 8'd126, 8'h00, 8'h00);

    // Largest legal scale with extreme colors.
    run_phase(6'd8, 6'd0, 6'd63, 6'd0, 30, 1'b0, 1'b0, 1'b0, 1'b0);
    // Scale 1 with the unused upper data bits set; no idling on either side.
    run_phase(6'h31, 6'd63, 6'd0, 6'd63, 30, 1'b1, 1'b1, 1'b0, 1'b0);
    // Scale 0 keeps the cursor still; the receiver stalls for a long stretch.
    run_phase(6'd0, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), 30, 1'b1, 1'b0, 1'b1, 1'b0);
    // Scale beyond the intended range; the sender pauses midway.
    run_phase(6'h0F, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), 30, 1'b0, 1'b0, 1'b0, 1'b1);
    run_phase(6'h32, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), 30, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(6'($urandom_range(0, 3) * 16 + $urandom_range(1, 8)),
              6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), 30, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(6'd3, 6'h2A, 6'h15, 6'h3F, 30, 1'b0, 1'b1, 1'b0, 1'b0);

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
